// ----- rtl/cau_pkg.sv -----
// Shared widths, codes, sideband type and saturation helper for the complex arithmetic unit.
`default_nettype none
package cau_pkg;

	localparam int DW    = 32;
	localparam int FB    = 16;
	localparam int PW    = 2 * DW;
	localparam int SW    = PW + 1;
	localparam int MAGW  = PW + 2;
	localparam int MW    = PW + FB;
	localparam int RW    = 3 * DW;
	localparam int IN_TW  = ((2 + 4 * DW + 7) / 8) * 8;
	localparam int OUT_TW = ((2 + 2 * DW + 7) / 8) * 8;
	localparam logic [MAGW-1:0] HALF = (FB == 0) ? '0 : (MAGW'(1) << ((FB == 0) ? 0 : FB - 1));

	typedef enum logic [1:0] {
		MODE_ADD = 2'd0,
		MODE_SUB = 2'd1,
		MODE_MUL = 2'd2,
		MODE_DIV = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_SAT = 2'd1,
		ST_DZ  = 2'd2
	} status_t;

	typedef struct packed {
		logic          is_div;
		logic          dz;
		logic [DW-1:0] re;
		logic [DW-1:0] im;
		logic [1:0]    status;
	} side_t;

	// Returns {saturated, value} for a sign and magnitude pair.
	function automatic logic [DW:0] sat_mag(input logic neg, input logic [MAGW-1:0] mag);
		logic [MAGW-1:0] lim;
		logic [DW:0]     ret;
		lim = MAGW'(1) << (DW - 1);
		if (!neg) begin
			if (mag >= lim) begin
				ret = {1'b1, 1'b0, {(DW-1){1'b1}}};
			end else begin
				ret = {1'b0, mag[DW-1:0]};
			end
		end else begin
			if (mag > lim) begin
				ret = {1'b1, 1'b1, {(DW-1){1'b0}}};
			end else begin
				ret = {1'b0, (~mag[DW-1:0]) + DW'(1)};
			end
		end
		return ret;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/cau_div.sv -----
// Pipelined restoring divider for both quotient components, with rounding and output merge.
`default_nettype none
module cau_div (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 in_valid,
	input  wire cau_pkg::side_t       in_side,
	input  wire logic [cau_pkg::MW-1:0] num_re,
	input  wire logic                 neg_re,
	input  wire logic [cau_pkg::MW-1:0] num_im,
	input  wire logic                 neg_im,
	input  wire logic [cau_pkg::PW-1:0] den,
	output logic                      out_valid,
	output logic [cau_pkg::DW-1:0]    out_re,
	output logic [cau_pkg::DW-1:0]    out_im,
	output logic [1:0]                out_status
);
	import cau_pkg::*;

	logic          vld_s   [0:DW];
	logic [RW-1:0] rre_s   [0:DW];
	logic [RW-1:0] rim_s   [0:DW];
	logic [DW-1:0] qre_s   [0:DW];
	logic [DW-1:0] qim_s   [0:DW];
	logic          ovre_s  [0:DW];
	logic          ovim_s  [0:DW];
	logic          nre_s   [0:DW];
	logic          nim_s   [0:DW];
	logic [PW-1:0] den_s   [0:DW];
	side_t         side_s  [0:DW];

	logic [RW-1:0] dtop;
	assign dtop = RW'(den) << DW;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rre_s[0]  <= RW'(num_re);
			rim_s[0]  <= RW'(num_im);
			qre_s[0]  <= '0;
			qim_s[0]  <= '0;
			ovre_s[0] <= RW'(num_re) >= dtop;
			ovim_s[0] <= RW'(num_im) >= dtop;
			nre_s[0]  <= neg_re;
			nim_s[0]  <= neg_im;
			den_s[0]  <= den;
			side_s[0] <= in_side;
		end
	end

	for (genvar k = 1; k <= DW; k++) begin : g_bit
		localparam int BIT = DW - k;
		logic [RW-1:0] dsh;
		logic          ge_re;
		logic          ge_im;
		assign dsh   = RW'(den_s[k-1]) << BIT;
		assign ge_re = rre_s[k-1] >= dsh;
		assign ge_im = rim_s[k-1] >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rre_s[k]  <= ge_re ? rre_s[k-1] - dsh : rre_s[k-1];
				rim_s[k]  <= ge_im ? rim_s[k-1] - dsh : rim_s[k-1];
				qre_s[k]  <= qre_s[k-1] | (DW'(ge_re) << BIT);
				qim_s[k]  <= qim_s[k-1] | (DW'(ge_im) << BIT);
				ovre_s[k] <= ovre_s[k-1];
				ovim_s[k] <= ovim_s[k-1];
				nre_s[k]  <= nre_s[k-1];
				nim_s[k]  <= nim_s[k-1];
				den_s[k]  <= den_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	logic            up_re;
	logic            up_im;
	logic [MAGW-1:0] mre;
	logic [MAGW-1:0] mim;
	logic [DW:0]     sre;
	logic [DW:0]     sim;
	side_t           sd;

	assign sd    = side_s[DW];
	assign up_re = {rre_s[DW][PW-1:0], 1'b0} >= {1'b0, den_s[DW]};
	assign up_im = {rim_s[DW][PW-1:0], 1'b0} >= {1'b0, den_s[DW]};
	assign mre   = ovre_s[DW] ? (MAGW'(1) << DW) : MAGW'(qre_s[DW]) + MAGW'(up_re);
	assign mim   = ovim_s[DW] ? (MAGW'(1) << DW) : MAGW'(qim_s[DW]) + MAGW'(up_im);
	assign sre   = sat_mag(nre_s[DW], mre);
	assign sim   = sat_mag(nim_s[DW], mim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld_s[DW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!sd.is_div) begin
				out_re     <= sd.re;
				out_im     <= sd.im;
				out_status <= sd.status;
			end else if (sd.dz) begin
				out_re     <= '0;
				out_im     <= '0;
				out_status <= ST_DZ;
			end else begin
				out_re     <= sre[DW-1:0];
				out_im     <= sim[DW-1:0];
				out_status <= (sre[DW] || sim[DW]) ? ST_SAT : ST_OK;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/complex_arithmetic_unit.sv -----
// Complex add, subtract, multiply and divide on Q15.16 operands with saturation.
// Input to output valid: four operand, product, sum and magnitude stages, then
// 34 divider stages (input register, one per quotient bit, output register).
// Throughput is one transaction per cycle; a stalled output holds the whole pipeline.
// Reset clears all valid bits; data registers are not reset.
`default_nettype none
module complex_arithmetic_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_axis_tvalid,
	output logic                            s_axis_tready,
	// mode, a_re, a_im, b_re, b_im from the lowest bit up, zero padded.
	input  wire logic [cau_pkg::IN_TW-1:0]  s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  wire logic                       m_axis_tready,
	// res_re, res_im, status from the lowest bit up, zero padded.
	output logic [cau_pkg::OUT_TW-1:0]      m_axis_tdata
);
	import cau_pkg::*;

	logic en;
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	logic                 v_s1, v_s2, v_s3, v_s4;
	mode_t                mode_s1, mode_s2, mode_s3;
	logic signed [DW-1:0] ar_s1, ai_s1, br_s1, bi_s1;
	logic signed [PW-1:0] ac_s2, bd_s2, ad_s2, bc_s2, cc_s2, dd_s2;
	logic signed [DW:0]   sre_s2, sim_s2, sre_s3, sim_s3;
	logic signed [SW-1:0] nre_s3, nim_s3;
	logic [PW-1:0]        den_s3, den_s4;
	logic [MW-1:0]        mre_s4, mim_s4;
	logic                 negre_s4, negim_s4;
	side_t                side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= mode_t'(s_axis_tdata[1:0]);
			ar_s1   <= s_axis_tdata[2 +: DW];
			ai_s1   <= s_axis_tdata[2 + DW +: DW];
			br_s1   <= s_axis_tdata[2 + 2 * DW +: DW];
			bi_s1   <= s_axis_tdata[2 + 3 * DW +: DW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s2 <= mode_s1;
			ac_s2   <= PW'(ar_s1) * PW'(br_s1);
			bd_s2   <= PW'(ai_s1) * PW'(bi_s1);
			ad_s2   <= PW'(ar_s1) * PW'(bi_s1);
			bc_s2   <= PW'(ai_s1) * PW'(br_s1);
			cc_s2   <= PW'(br_s1) * PW'(br_s1);
			dd_s2   <= PW'(bi_s1) * PW'(bi_s1);
			if (mode_s1 == MODE_ADD) begin
				sre_s2 <= (DW+1)'(ar_s1) + (DW+1)'(br_s1);
				sim_s2 <= (DW+1)'(ai_s1) + (DW+1)'(bi_s1);
			end else begin
				sre_s2 <= (DW+1)'(ar_s1) - (DW+1)'(br_s1);
				sim_s2 <= (DW+1)'(ai_s1) - (DW+1)'(bi_s1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s3 <= mode_s2;
			sre_s3  <= sre_s2;
			sim_s3  <= sim_s2;
			den_s3  <= $unsigned(cc_s2) + $unsigned(dd_s2);
			if (mode_s2 == MODE_DIV) begin
				nre_s3 <= SW'(ac_s2) + SW'(bd_s2);
				nim_s3 <= SW'(bc_s2) - SW'(ad_s2);
			end else begin
				nre_s3 <= SW'(ac_s2) - SW'(bd_s2);
				nim_s3 <= SW'(ad_s2) + SW'(bc_s2);
			end
		end
	end

	logic            nre_neg, nim_neg, are_neg, aim_neg;
	logic [SW-1:0]   nre_mag, nim_mag;
	logic [DW:0]     are_mag, aim_mag;
	logic [MAGW-1:0] pre_mag, pim_mag, fre_mag, fim_mag;
	logic [DW:0]     fre, fim;

	assign nre_neg = nre_s3[SW-1];
	assign nim_neg = nim_s3[SW-1];
	assign nre_mag = nre_neg ? -nre_s3 : nre_s3;
	assign nim_mag = nim_neg ? -nim_s3 : nim_s3;
	assign are_neg = sre_s3[DW];
	assign aim_neg = sim_s3[DW];
	assign are_mag = are_neg ? -sre_s3 : sre_s3;
	assign aim_mag = aim_neg ? -sim_s3 : sim_s3;
	assign pre_mag = (MAGW'(nre_mag) + HALF) >> FB;
	assign pim_mag = (MAGW'(nim_mag) + HALF) >> FB;
	assign fre_mag = (mode_s3 == MODE_MUL) ? pre_mag : MAGW'(are_mag);
	assign fim_mag = (mode_s3 == MODE_MUL) ? pim_mag : MAGW'(aim_mag);
	assign fre     = sat_mag((mode_s3 == MODE_MUL) ? nre_neg : are_neg, fre_mag);
	assign fim     = sat_mag((mode_s3 == MODE_MUL) ? nim_neg : aim_neg, fim_mag);

	always_ff @(posedge clk) begin
		if (en) begin
			mre_s4         <= MW'(nre_mag[PW-1:0]) << FB;
			mim_s4         <= MW'(nim_mag[PW-1:0]) << FB;
			negre_s4       <= nre_neg;
			negim_s4       <= nim_neg;
			den_s4         <= den_s3;
			side_s4.is_div <= mode_s3 == MODE_DIV;
			side_s4.dz     <= den_s3 == '0;
			side_s4.re     <= fre[DW-1:0];
			side_s4.im     <= fim[DW-1:0];
			side_s4.status <= (fre[DW] || fim[DW]) ? ST_SAT : ST_OK;
		end
	end

	logic [DW-1:0] res_re, res_im;
	logic [1:0]    status;

	cau_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (v_s4),
		.in_side    (side_s4),
		.num_re     (mre_s4),
		.neg_re     (negre_s4),
		.num_im     (mim_s4),
		.neg_im     (negim_s4),
		.den        (den_s4),
		.out_valid  (m_axis_tvalid),
		.out_re     (res_re),
		.out_im     (res_im),
		.out_status (status)
	);

	assign m_axis_tdata = OUT_TW'({status, res_im, res_re});

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && status == ST_DZ |-> res_re == '0 && res_im == '0)
		else $error("divide by zero result is not zero");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input accepted while output stalled");

	a_s1_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(v_s1) |-> $past(s_axis_tvalid && s_axis_tready))
		else $error("first stage valid without an input transaction");

endmodule
`default_nettype wire
